>>> hw/rtl/fspa_pkg.sv
// Shared constants for the fixed slot pool allocator.
package fspa_pkg;

  // Default pool size in slots
  localparam int unsigned CAPACITY_DEF = 256;

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned FREE_W  = 17;

  // Stream payload widths (packed, zero filled to whole bytes)
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 56;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHIFT = 1'b1;

  // Operation codes carried on s_tuser
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  // Effective slot shift limits
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;

endpackage

>>> hw/rtl/fixed_slot_pool_allocator.sv
// Fixed slot pool allocator: LIFO free list of slot indices with stream ports.
// Results: stage 1 reads the stack RAM, stage 2 registers the result.
// Throughput: one transaction per cycle; the stack RAM does one pop read or one
// push write per cycle, so a request follows next cycle unless m_tready stalls.
// Reset: rst (synchronous) fills the pool at once: a low-water mark stands in
// for the reset contents of the stack, so there is no clearing pass.
module fixed_slot_pool_allocator #(
  parameter int unsigned CAPACITY = fspa_pkg::CAPACITY_DEF  // 1 .. 65536
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fspa_pkg::ADDR_W-1:0]    cfg_data,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: request_size[30:0], slot_address[62:31], zero [63]
  input  logic [fspa_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: func[0] (0 allocate, 1 free)
  input  logic                           s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: result_address[31:0], pooled[32], free_slots[49:33], zero [55:50]
  output logic [fspa_pkg::M_TDATA_W-1:0] m_tdata
);
  import fspa_pkg::*;

  // Slot index and count widths follow the pool size
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  pool_base;
  logic [SHIFT_W-1:0] slot_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      slot_shift <= SHIFT_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_BASE:  pool_base  <= cfg_data;
        REG_SLOT_SHIFT: slot_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range shifts are clamped to the legal slot sizes
  logic [SHIFT_W-1:0] shift_eff;
  always_comb begin
    if (slot_shift < SHIFT_MIN)      shift_eff = SHIFT_MIN;
    else if (slot_shift > SHIFT_MAX) shift_eff = SHIFT_MAX;
    else                             shift_eff = slot_shift;
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  func_t              in_func;
  logic [SIZE_W-1:0]  in_size;
  logic [ADDR_W-1:0]  in_addr;

  assign in_func = func_t'(s_tuser);
  assign in_size = s_tdata[SIZE_W-1:0];
  assign in_addr = s_tdata[SIZE_W +: ADDR_W];

  // Stack state: count of free slots and low-water mark. Entries below the
  // mark were never written since reset and still hold their reset value,
  // i.e. their own index; entries at or above it are read from the RAM.
  logic [CNT_W-1:0] free_count, free_count_next;
  logic [CNT_W-1:0] low_mark, low_mark_next;

  logic              size_fits;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] offset_slot;
  logic              addr_in_pool;
  logic              do_pop, do_push;
  logic [CNT_W-1:0]  top;          // free_count - 1
  logic              top_is_reset; // pop hits an entry never written

  always_comb begin
    size_fits    = {1'b0, in_size} <= (ADDR_W'(1) << shift_eff);
    offset       = in_addr - pool_base;
    offset_slot  = offset >> shift_eff;
    addr_in_pool = (in_addr >= pool_base) && (offset_slot < ADDR_W'(CAPACITY));
    top          = free_count - CNT_W'(1);
    top_is_reset = top < low_mark;

    do_pop  = (in_func == FUNC_ALLOC) && size_fits && (free_count != '0);
    do_push = (in_func == FUNC_FREE) && addr_in_pool && (free_count != CNT_FULL);
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: stage 1 holds the RAM read, stage 2 the result register
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic out_valid;
  logic out_load;
  logic in_accept;

  assign out_load  = s1_valid && (!out_valid || m_tready);
  assign s_tready  = !s1_valid || out_load;
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    free_count_next = free_count;
    low_mark_next   = low_mark;
    if (in_accept && do_pop) begin
      free_count_next = top;
      if (top_is_reset) low_mark_next = top;
    end else if (in_accept && do_push) begin
      free_count_next = free_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= CNT_FULL;
      low_mark   <= CNT_FULL;
    end else begin
      free_count <= free_count_next;
      low_mark   <= low_mark_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Free-list stack RAM: one write (push) or one registered read (pop) a cycle
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] stack_mem [CAPACITY];
  logic [IDX_W-1:0] stack_rdata;

  always_ff @(posedge clk) begin
    if (in_accept && do_push) begin
      stack_mem[free_count[IDX_W-1:0]] <= offset_slot[IDX_W-1:0];
    end
    if (in_accept && do_pop) begin
      stack_rdata <= stack_mem[top[IDX_W-1:0]];
    end
  end

  // Stage 1 payload
  logic             s1_pooled;
  logic             s1_alloc;
  logic             s1_use_rst;
  logic [IDX_W-1:0] s1_rst_idx;
  logic [CNT_W-1:0] s1_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pooled  <= do_pop || do_push;
      s1_alloc   <= do_pop;
      s1_use_rst <= top_is_reset;
      s1_rst_idx <= top[IDX_W-1:0];
      s1_count   <= free_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: slot address and result register
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  pop_idx;
  logic [ADDR_W-1:0] slot_addr;
  logic [ADDR_W-1:0] out_addr;
  logic              out_pooled;
  logic [CNT_W-1:0]  out_count;

  assign pop_idx   = s1_use_rst ? s1_rst_idx : stack_rdata;
  assign slot_addr = pool_base + (ADDR_W'(pop_idx) << shift_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr   <= s1_alloc ? slot_addr : '0;
      out_pooled <= s1_pooled;
      out_count  <= s1_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - ADDR_W - 1 - FREE_W)'(0),
                     FREE_W'(out_count), out_pooled, out_addr};

endmodule
